>>> src/array_focus_phase_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef ARRAY_FOCUS_PHASE_UNIT_ASSERT_SVH
`define ARRAY_FOCUS_PHASE_UNIT_ASSERT_SVH

// Plain clocked assertion, disabled during reset.
`define AFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define AFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/afp_pkg.sv
`default_nettype none
package afp_pkg;

  localparam int unsigned PHASE_MOD = 92160;
  localparam int unsigned PH_W = 17;
  localparam int unsigned RAD_W = 60;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned SIDE_W = 2 * PH_W;
  localparam int unsigned SQ_STAGES = ROOT_W / 2;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_STEP_X = 3'd2;
  localparam logic [2:0] REG_STEP_Y = 3'd3;
  localparam logic [2:0] REG_FOCUS = 3'd4;
  localparam logic [2:0] REG_DPU = 3'd5;

  // Remainder modulo 45 of a value below 720.
  function automatic logic [5:0] mod45(input logic [8:0] x);
    logic [9:0] r;
    r = {1'b0, x};
    if (r >= 10'd360) r = r - 10'd360;
    if (r >= 10'd180) r = r - 10'd180;
    if (r >= 10'd90) r = r - 10'd90;
    if (r >= 10'd45) r = r - 10'd45;
    return r[5:0];
  endfunction

endpackage
`default_nettype wire

>>> src/afp_sqrt.sv
`default_nettype none
module afp_sqrt import afp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [RAD_W-1:0]  in_rad,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      out_root,
  output logic [SIDE_W-1:0]      out_side
);

  logic              vld  [SQ_STAGES];
  logic [REM_W-1:0]  rem  [SQ_STAGES];
  logic [ROOT_W-1:0] root [SQ_STAGES];
  logic [RAD_W-1:0]  rad  [SQ_STAGES];
  logic [SIDE_W-1:0] side [SQ_STAGES];

  function automatic logic [REM_W+ROOT_W-1:0] sq_step(
    input logic [REM_W-1:0] r_in, input logic [ROOT_W-1:0] q_in, input logic [1:0] b);
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] t;
    logic [ROOT_W-1:0] q;
    r2 = {r_in, b};
    t = {2'b00, q_in, 2'b01};
    q = q_in;
    if (r2 >= t) begin
      r2 = r2 - t;
      q = {q[ROOT_W-2:0], 1'b1};
    end else begin
      q = {q[ROOT_W-2:0], 1'b0};
    end
    return {r2[REM_W-1:0], q};
  endfunction

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic              pv;
    logic [REM_W-1:0]  pr;
    logic [ROOT_W-1:0] pq;
    logic [RAD_W-1:0]  pd;
    logic [SIDE_W-1:0] ps;
    logic [REM_W+ROOT_W-1:0] s1;
    logic [REM_W+ROOT_W-1:0] s2;
    if (g == 0) begin : g_first
      assign pv = in_valid;
      assign pr = '0;
      assign pq = '0;
      assign pd = in_rad;
      assign ps = in_side;
    end else begin : g_next
      assign pv = vld[g-1];
      assign pr = rem[g-1];
      assign pq = root[g-1];
      assign pd = rad[g-1];
      assign ps = side[g-1];
    end
    always_comb begin
      s1 = sq_step(pr, pq, pd[RAD_W-1:RAD_W-2]);
      s2 = sq_step(s1[REM_W+ROOT_W-1:ROOT_W], s1[ROOT_W-1:0], pd[RAD_W-3:RAD_W-4]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= pv;
      end
      if (en) begin
        rem[g] <= s2[REM_W+ROOT_W-1:ROOT_W];
        root[g] <= s2[ROOT_W-1:0];
        rad[g] <= {pd[RAD_W-5:0], 4'b0000};
        side[g] <= ps;
      end
    end
  end

  assign out_valid = vld[SQ_STAGES-1];
  assign out_root = root[SQ_STAGES-1];
  assign out_side = side[SQ_STAGES-1];

endmodule
`default_nettype wire

>>> src/array_focus_phase_unit.sv
// Per-element focusing phase for a phased array.
// A request on the s_ side names one element by grid column and row and
// carries its own phase and an added phase. Each request gives exactly one
// result on the m_ side: the focusing phase and the wrapped total phase,
// both in degrees with 8 fraction bits, in the range 0 to 92159.
// The user must write the configuration port only while no request is in
// flight (not enforced here); writes to indexes above 5 are ignored.
// The pipeline is 23 registers deep, the first loaded at the edge that takes
// the request, the last holding m_tdata. One request is taken every cycle
// while the pipeline is not stalled; the 15-stage square root, two result
// bits per stage, sets the depth, not the rate.
// Reset clears all configuration registers to zero and empties the pipeline.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready drops in the same cycle; nothing is lost or
// repeated, and flow resumes the cycle m_tready returns.
`default_nettype none
module array_focus_phase_unit import afp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // grid_col[8:0], grid_row[17:9], own_phase[34:18], add_phase[51:35], zero pad.
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // focus_phase[16:0], total_phase[33:17], zero pad.
  output logic [39:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam logic [PH_W-1:0] MOD = PH_W'(PHASE_MOD);

  logic signed [10:0] center_x, center_y;
  logic [15:0] step_x, step_y;
  logic [19:0] focus_distance;
  logic [23:0] degrees_per_unit;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      step_x <= '0;
      step_y <= '0;
      focus_distance <= '0;
      degrees_per_unit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data[10:0];
        REG_CENTER_Y: center_y <= cfg_data[10:0];
        REG_STEP_X: step_x <= cfg_data[15:0];
        REG_STEP_Y: step_y <= cfg_data[15:0];
        REG_FOCUS: focus_distance <= cfg_data[19:0];
        REG_DPU: degrees_per_unit <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [PH_W-1:0] own_in, add_in, own_red, add_red;
  logic signed [11:0] dx2, dy2;
  logic [10:0] ax_next, ay_next;

  always_comb begin
    own_in = s_tdata[34:18];
    add_in = s_tdata[51:35];
    own_red = (own_in >= MOD) ? own_in - MOD : own_in;
    add_red = (add_in >= MOD) ? add_in - MOD : add_in;
    dx2 = $signed({2'b00, s_tdata[8:0], 1'b0}) - 12'(center_x);
    dy2 = $signed({2'b00, s_tdata[17:9], 1'b0}) - 12'(center_y);
    ax_next = dx2[11] ? 11'(-dx2) : dx2[10:0];
    ay_next = dy2[11] ? 11'(-dy2) : dy2[10:0];
  end

  logic v1, v2, v3, v4, v5, v6, v7;
  logic [SIDE_W-1:0] side1, side2, side3, side4, side5, side6, side7;
  logic [10:0] ax1, ay1;
  logic [26:0] xc2, yc2;
  logic [53:0] xsq, ysq;
  logic [39:0] fsq;
  logic [RAD_W-1:0] rad4;
  logic sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [SIDE_W-1:0] sq_side;
  logic [ROOT_W-1:0] d5;
  logic [53:0] prod6;
  logic [8:0] fold7;
  logic [10:0] low7;
  logic [55:0] sum_next;
  logic [22:0] f8;
  logic [31:0] hi;
  logic [13:0] r1;
  logic [10:0] r2;
  logic [8:0] r3;
  logic [PH_W-1:0] m_val, focus_next, own7, add7, fa, total_next;

  always_comb begin
    sum_next = {2'b00, xsq} + {2'b00, ysq} + {14'b0, fsq, 2'b00};
    f8 = {focus_distance, 3'b000};
    hi = prod6[53:22];
    r1 = 14'(hi[7:0]) + 14'(hi[15:8]) * 14'd31 + 14'(hi[23:16]) * 14'd16 + 14'(hi[31:24]);
    r2 = 11'(r1[7:0]) + 11'(r1[13:8]) * 11'd31;
    r3 = 9'(r2[7:0]) + 9'(r2[10:8]) * 9'd31;
    m_val = {mod45(fold7), low7};
    focus_next = (m_val == '0) ? '0 : MOD - m_val;
    own7 = side7[PH_W-1:0];
    add7 = side7[SIDE_W-1:PH_W];
    fa = 17'((18'(focus_next) + 18'(add7) >= 18'(MOD)) ?
             18'(focus_next) + 18'(add7) - 18'(MOD) : 18'(focus_next) + 18'(add7));
    total_next = (fa >= own7) ? fa - own7 : 17'(18'(fa) + 18'(MOD) - 18'(own7));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= sq_valid;
      v6 <= v5;
      v7 <= v6;
      m_tvalid <= v7;
    end
    if (en) begin
      ax1 <= ax_next;
      ay1 <= ay_next;
      side1 <= {add_red, own_red};
      xc2 <= 27'(ax1) * 27'(step_x);
      yc2 <= 27'(ay1) * 27'(step_y);
      side2 <= side1;
      xsq <= 54'(xc2) * 54'(xc2);
      ysq <= 54'(yc2) * 54'(yc2);
      fsq <= 40'(focus_distance) * 40'(focus_distance);
      side3 <= side2;
      rad4 <= {sum_next, 4'b0000};
      side4 <= side3;
      d5 <= (sq_root > ROOT_W'(f8)) ? sq_root - ROOT_W'(f8) : '0;
      side5 <= sq_side;
      prod6 <= 54'(degrees_per_unit) * 54'(d5);
      side6 <= side5;
      fold7 <= r3;
      low7 <= prod6[21:11];
      side7 <= side6;
      m_tdata <= {6'b0, total_next, focus_next};
    end
  end

  afp_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v4),
    .in_rad(rad4),
    .in_side(side4),
    .out_valid(sq_valid),
    .out_root(sq_root),
    .out_side(sq_side)
  );

endmodule
`default_nettype wire

>>> src/afp_checker.sv
`default_nettype none
`include "array_focus_phase_unit_assert.svh"
module afp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  logic phases_ok;
  assign phases_ok = (m_tdata[16:0] < 17'd92160) && (m_tdata[33:17] < 17'd92160) &&
                     (m_tdata[39:34] == 6'd0);

  `AFP_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid right after reset")
  `AFP_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")
  `AFP_ASSERT(a_ready_stall, (m_tvalid && !m_tready) |-> !s_tready, "request taken during stall")
  `AFP_ASSERT(a_range, m_tvalid |-> phases_ok, "phase out of range")

endmodule

bind array_focus_phase_unit afp_checker u_afp_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);
`default_nettype wire
